[rtl/lat_pkg.sv]
`default_nettype none
package lat_pkg;

    localparam int unsigned DIM_W      = 16;
    localparam int unsigned TOL_W      = 8;
    localparam int unsigned RATIO_IDX_W = 2;
    localparam int unsigned NUM_RATIOS = 3;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned QUO_W      = DIM_W + FRAC_BITS;
    localparam int unsigned DIV_STEPS  = QUO_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [DIM_W-1:0] DIM_UNKNOWN = 16'hffff;

    localparam logic [TOL_W-1:0] RES_TOL_RST      = 8'd8;
    localparam logic [TOL_W-1:0] BAR_MARGIN_RST   = 8'd4;
    localparam logic [TOL_W-1:0] FULL_LIMIT_RST   = 8'd10;
    localparam logic [TOL_W-1:0] CENTER_TOL_RST   = 8'd20;
    localparam logic [TOL_W-1:0] RATIO_TOL_RST    = 8'd25;
    localparam logic [DIM_W-1:0] RATIO_WIDE_RST   = 16'd455;
    localparam logic [DIM_W-1:0] RATIO_CINEMA_RST = 16'd614;
    localparam logic [DIM_W-1:0] RATIO_CLASSIC_RST = 16'd340;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RES_TOL       = 3'd0,
        CFG_BAR_MARGIN    = 3'd1,
        CFG_FULL_LIMIT    = 3'd2,
        CFG_CENTER_TOL    = 3'd3,
        CFG_RATIO_TOL     = 3'd4,
        CFG_RATIO_WIDE    = 3'd5,
        CFG_RATIO_CINEMA  = 3'd6,
        CFG_RATIO_CLASSIC = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_MATCH,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

[rtl/letterbox_aspect_tracker_top.sv]
`default_nettype none
// channel   dir  tdata fields (low bit up)                              tuser
// s_*       in   frame_width, left_bar, right_bar, frame_height,         operation
//                top_bar, bottom_bar (16 bits each, 96 bits)
// m_*       out  format_changed, current_width, current_height,          -
//                current_ratio, 5 zero bits (40 bits)
// cfg_*     in   write enable, register index 0..7, 16-bit data          -
//
// a suspend item, or one with no bar pattern to test, passes from the transfer through ST_EVAL and ST_FINISH
// an item with a ratio test goes from ST_EVAL to ST_DIV, where it waits on the bit-serial divider
// (24 steps plus its done flag), then to ST_MATCH, which compares against the known ratios one at
// a time until one hits or all three are tried, then to ST_FINISH
// reset loads the default register values and clears tracking to unknown size
// a result waiting in the output register does not block the next input transfer; the block
// only stalls at the end of an item until that register is free
module letterbox_aspect_tracker_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lat_pkg::IN_DATA_W-1:0]    s_tdata,   // frame_width, left_bar, right_bar,
                                                             // frame_height, top_bar, bottom_bar
    input  wire logic                             s_tuser,   // operation
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [lat_pkg::OUT_DATA_W-1:0]        m_tdata,   // format_changed, current_width,
                                                             // current_height, current_ratio
    input  wire logic                             cfg_we,
    input  wire logic [lat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lat_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lat_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [TOL_W-1:0] res_tol_reg, bar_margin_reg, full_limit_reg, center_tol_reg, ratio_tol_reg;
    logic [DIM_W-1:0] known_reg [NUM_RATIOS];

    // captured item
    logic             op_reg;
    logic [DIM_W-1:0] fw_reg, lb_reg, rb_reg, fh_reg, tb_reg, bb_reg;

    // tracking state
    logic [DIM_W-1:0]       tw_reg, tw_next, th_reg, th_next;
    logic [RATIO_IDX_W-1:0] ratio_reg, ratio_next;
    logic [DIM_W-1:0]       min_l_reg, min_l_next, min_r_reg, min_r_next;
    logic [DIM_W-1:0]       min_t_reg, min_t_next, min_b_reg, min_b_next;
    logic                   changed_reg, changed_next;
    logic                   letter_reg, letter_next;
    logic [RATIO_IDX_W-1:0] idx_reg, idx_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic [DIM_W-1:0] aw, ah;
    logic             drift, shrunk, lb_none, tb_none, lr_cent, tb_cent, letter, pillar;
    logic             div_start, div_done, hit;
    logic [QUO_W-1:0] ratio_q;
    logic [DIM_W-1:0] known_sel;
    logic [DIM_W-1:0] lr_diff, tb_diff;

    function automatic logic outside_tol(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] t,
                                         input logic [TOL_W-1:0] tol);
        logic [DIM_W:0] m_ext, t_ext, tol_ext;
        m_ext   = {1'b0, m};
        t_ext   = {1'b0, t};
        tol_ext = (DIM_W + 1)'(tol);
        return (m_ext + tol_ext < t_ext) || (m_ext > t_ext + tol_ext);
    endfunction

    function automatic logic [DIM_W-1:0] bound_of(input logic [DIM_W-1:0] bar,
                                                  input logic [TOL_W-1:0] margin);
        logic [DIM_W-1:0] m_ext;
        m_ext = DIM_W'(margin);
        return (bar > m_ext) ? bar - m_ext : '0;
    endfunction

    lat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({aw, {FRAC_BITS{1'b0}}}),
        .divisor  (ah),
        .done     (div_done),
        .quotient (ratio_q)
    );

    always_comb
    begin
        aw      = fw_reg - lb_reg - rb_reg;
        ah      = fh_reg - tb_reg - bb_reg;
        lr_diff = (lb_reg > rb_reg) ? lb_reg - rb_reg : rb_reg - lb_reg;
        tb_diff = (tb_reg > bb_reg) ? tb_reg - bb_reg : bb_reg - tb_reg;
        lb_none = ({1'b0, lb_reg} + {1'b0, rb_reg}) <= (DIM_W + 1)'(full_limit_reg);
        tb_none = ({1'b0, tb_reg} + {1'b0, bb_reg}) <= (DIM_W + 1)'(full_limit_reg);
        lr_cent = lr_diff <= DIM_W'(center_tol_reg);
        tb_cent = tb_diff <= DIM_W'(center_tol_reg);
        letter  = lb_none && tb_cent;
        pillar  = tb_none && lr_cent;
        drift   = outside_tol(fw_reg, tw_reg, res_tol_reg) ||
                  outside_tol(fh_reg, th_reg, res_tol_reg);
        shrunk  = (lb_reg < min_l_reg) || (rb_reg < min_r_reg) ||
                  (tb_reg < min_t_reg) || (bb_reg < min_b_reg);
        known_sel = known_reg[idx_reg];
        // strict window around the known ratio
        hit = ({1'b0, ratio_q} + (QUO_W + 1)'(ratio_tol_reg) > (QUO_W + 1)'(known_sel)) &&
              ({1'b0, ratio_q} < (QUO_W + 1)'(known_sel) + (QUO_W + 1)'(ratio_tol_reg));
    end

    always_comb
    begin
        state_next   = state_reg;
        tw_next      = tw_reg;
        th_next      = th_reg;
        ratio_next   = ratio_reg;
        min_l_next   = min_l_reg;
        min_r_next   = min_r_reg;
        min_t_next   = min_t_reg;
        min_b_next   = min_b_reg;
        changed_next = changed_reg;
        letter_next  = letter_reg;
        idx_next     = idx_reg;
        div_start    = 1'b0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                changed_next = 1'b0;
                if (op_reg)
                begin
                    ratio_next = '0;
                    tw_next    = DIM_UNKNOWN;
                    th_next    = DIM_UNKNOWN;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (drift || shrunk)
                    begin
                        ratio_next   = '0;
                        tw_next      = fw_reg;
                        th_next      = fh_reg;
                        min_l_next   = '0;
                        min_r_next   = '0;
                        min_t_next   = '0;
                        min_b_next   = '0;
                        changed_next = 1'b1;
                    end
                    letter_next = letter;
                    idx_next    = '0;
                    if ((letter || pillar) && (ah != '0))
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                if (hit)
                begin
                    if (idx_reg != ratio_reg)
                    begin
                        ratio_next   = idx_reg;
                        changed_next = 1'b1;
                        if (letter_reg)
                        begin
                            min_l_next = '0;
                            min_r_next = '0;
                            min_t_next = bound_of(tb_reg, bar_margin_reg);
                            min_b_next = bound_of(bb_reg, bar_margin_reg);
                        end
                        else
                        begin
                            min_l_next = bound_of(lb_reg, bar_margin_reg);
                            min_r_next = bound_of(rb_reg, bar_margin_reg);
                            min_t_next = '0;
                            min_b_next = '0;
                        end
                    end
                    state_next = ST_FINISH;
                end
                else if (idx_reg == RATIO_IDX_W'(NUM_RATIOS - 1))
                    state_next = ST_FINISH;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_W'({ratio_reg, th_reg, tw_reg, changed_reg});
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg      <= DIM_UNKNOWN;
            th_reg      <= DIM_UNKNOWN;
            ratio_reg   <= '0;
            min_l_reg   <= '0;
            min_r_reg   <= '0;
            min_t_reg   <= '0;
            min_b_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            tw_reg      <= tw_next;
            th_reg      <= th_next;
            ratio_reg   <= ratio_next;
            min_l_reg   <= min_l_next;
            min_r_reg   <= min_r_next;
            min_t_reg   <= min_t_next;
            min_b_reg   <= min_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        changed_reg <= changed_next;
        letter_reg  <= letter_next;
        idx_reg     <= idx_next;
        m_data_reg  <= m_data_next;
        if (s_tvalid && s_tready)
        begin
            op_reg <= s_tuser;
            fw_reg <= s_tdata[15:0];
            lb_reg <= s_tdata[31:16];
            rb_reg <= s_tdata[47:32];
            fh_reg <= s_tdata[63:48];
            tb_reg <= s_tdata[79:64];
            bb_reg <= s_tdata[95:80];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_tol_reg    <= RES_TOL_RST;
            bar_margin_reg <= BAR_MARGIN_RST;
            full_limit_reg <= FULL_LIMIT_RST;
            center_tol_reg <= CENTER_TOL_RST;
            ratio_tol_reg  <= RATIO_TOL_RST;
            known_reg[0]   <= RATIO_WIDE_RST;
            known_reg[1]   <= RATIO_CINEMA_RST;
            known_reg[2]   <= RATIO_CLASSIC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RES_TOL:       res_tol_reg    <= cfg_data[TOL_W-1:0];
                CFG_BAR_MARGIN:    bar_margin_reg <= cfg_data[TOL_W-1:0];
                CFG_FULL_LIMIT:    full_limit_reg <= cfg_data[TOL_W-1:0];
                CFG_CENTER_TOL:    center_tol_reg <= cfg_data[TOL_W-1:0];
                CFG_RATIO_TOL:     ratio_tol_reg  <= cfg_data[TOL_W-1:0];
                CFG_RATIO_WIDE:    known_reg[0]   <= cfg_data[DIM_W-1:0];
                CFG_RATIO_CINEMA:  known_reg[1]   <= cfg_data[DIM_W-1:0];
                CFG_RATIO_CLASSIC: known_reg[2]   <= cfg_data[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

[rtl/lat_div.sv]
`default_nettype none
module lat_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lat_pkg::QUO_W-1:0]   dividend,
    input  wire logic [lat_pkg::DIM_W-1:0]   divisor,
    output logic                             done,
    output logic [lat_pkg::QUO_W-1:0]        quotient
);
    import lat_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DIM_W-1:0]     dvs_reg, dvs_next;
    logic [DIM_W:0]       shifted;
    logic [DIM_W:0]       diff;
    logic                 ge;

    // one restoring step per cycle, dividend bits shift out of quo_reg as quotient shifts in
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[QUO_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/lat_chk.sv]
`default_nettype none
module lat_chk (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [lat_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import lat_pkg::*;

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no transfer right after a transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while item in progress");

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:33] != 2'd3) && (m_tdata[39:35] == 5'd0))
        else $error("ratio index or padding out of range");

endmodule

bind letterbox_aspect_tracker_top lat_chk u_lat_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
